/* rtl/core/exl_pkg.sv */
// shared types and constants for the expression lexer
package exl_pkg;

    localparam int POS_BITS    = 32;
    localparam int SLOTS       = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [4:0] {
        KIND_NUMBER = 5'd0,
        KIND_IDENT  = 5'd1,
        KIND_STRING = 5'd2,
        KIND_GT     = 5'd3,
        KIND_GE     = 5'd4,
        KIND_LT     = 5'd5,
        KIND_LE     = 5'd6,
        KIND_ASSIGN = 5'd7,
        KIND_EQ     = 5'd8,
        KIND_BANG   = 5'd9,
        KIND_NE     = 5'd10,
        KIND_PLUS   = 5'd11,
        KIND_MINUS  = 5'd12,
        KIND_MUL    = 5'd13,
        KIND_DIV    = 5'd14,
        KIND_LPAREN = 5'd15,
        KIND_RPAREN = 5'd16,
        KIND_END    = 5'd17
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SYMBOL = 2'd1,
        ERR_QUOTE  = 2'd2
    } err_t;

    typedef struct packed {
        kind_t       kind;
        err_t        err;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
    } token_t;

    // all tokens produced by one input character, in emission order
    typedef struct packed {
        logic [SLOTS-1:0]   mask;
        token_t [SLOTS-1:0] slot;
    } bundle_t;

endpackage

/* rtl/core/exl_front.sv */
// scanner front end: character classification, scan state and token building
module exl_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       character,
    input  logic             end_of_text,
    input  logic             queue_full,
    output logic             in_stall,
    output logic             push,
    output exl_pkg::bundle_t bundle
);
    import exl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_STRING,
        MODE_OPERATOR
    } mode_t;

    typedef enum logic [1:0] {
        OP_GT,
        OP_LT,
        OP_ASSIGN,
        OP_BANG
    } op_t;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    mode_t                mode_reg, mode_next;
    op_t                  pend_reg, pend_next;
    logic                 quote_reg, quote_next;
    logic [POS_BITS-1:0]  tstart_reg, tstart_next;
    logic [POS_BITS-1:0]  pos_reg;
    logic [31:0]          line_reg, line_next;
    logic                 halt_reg, halt_next;

    logic                 take;
    logic                 consumed;
    logic                 is_digit;
    logic                 is_alpha;
    logic [POS_BITS-1:0]  pos_end;
    logic [POS_BITS-1:0]  diff_cur;
    logic [POS_BITS-1:0]  diff_end;
    logic [31:0]          line_inc;

    function automatic token_t make_token(kind_t kind, err_t err,
                                          logic [POS_BITS-1:0] start,
                                          logic [31:0] len, logic [31:0] line);
        token_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = 32'(start);
        t.len   = len;
        t.line  = line;
        return t;
    endfunction

    function automatic kind_t op_kind(op_t op, logic paired);
        kind_t k;
        unique case (op)
            OP_GT:     k = paired ? KIND_GE : KIND_GT;
            OP_LT:     k = paired ? KIND_LE : KIND_LT;
            OP_ASSIGN: k = paired ? KIND_EQ : KIND_ASSIGN;
            default:   k = paired ? KIND_NE : KIND_BANG;
        endcase
        return k;
    endfunction

    assign in_stall = queue_full;
    assign take     = in_valid && !queue_full;
    assign push     = take && (|bundle.mask);

    assign is_digit = (character >= 8'h30) && (character <= 8'h39);
    assign is_alpha = ((character >= 8'h61) && (character <= 8'h7A)) ||
                      ((character >= 8'h41) && (character <= 8'h5A));
    // position saturates at all ones
    assign pos_end  = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    assign line_inc = (&line_reg) ? line_reg : line_reg + 1'b1;
    assign diff_cur = pos_reg - tstart_reg;
    assign diff_end = pos_end - tstart_next;

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        quote_next  = quote_reg;
        tstart_next = tstart_reg;
        line_next   = line_reg;
        halt_next   = halt_reg;
        consumed    = 1'b0;
        bundle      = '0;

        if (!halt_reg)
        begin
            // close or extend the token in progress
            unique case (mode_reg)
                MODE_NUMBER:
                begin
                    if (is_digit || character == CH_DOT)
                    begin
                        consumed = 1'b1;
                    end
                    else
                    begin
                        bundle.mask[0] = 1'b1;
                        bundle.slot[0] = make_token(KIND_NUMBER, ERR_NONE, tstart_reg,
                                                    32'(diff_cur), line_reg);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_digit || is_alpha)
                    begin
                        consumed = 1'b1;
                    end
                    else
                    begin
                        bundle.mask[0] = 1'b1;
                        bundle.slot[0] = make_token(KIND_IDENT, ERR_NONE, tstart_reg,
                                                    32'(diff_cur), line_reg);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_OPERATOR:
                begin
                    consumed       = (character == CH_EQ);
                    bundle.mask[0] = 1'b1;
                    bundle.slot[0] = make_token(op_kind(pend_reg, consumed), ERR_NONE,
                                                tstart_reg, consumed ? 32'd2 : 32'd1,
                                                line_reg);
                    mode_next = MODE_IDLE;
                end
                MODE_STRING:
                begin
                    consumed = 1'b1;
                    if (character == (quote_reg ? CH_APOS : CH_QUOTE))
                    begin
                        bundle.mask[0] = 1'b1;
                        bundle.slot[0] = make_token(KIND_STRING, ERR_NONE, tstart_reg,
                                                    32'(diff_cur), line_reg);
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            // start a new token or emit a single-character one
            if (!consumed)
            begin
                if (is_digit)
                begin
                    mode_next   = MODE_NUMBER;
                    tstart_next = pos_reg;
                end
                else if (is_alpha)
                begin
                    mode_next   = MODE_IDENT;
                    tstart_next = pos_reg;
                end
                else
                begin
                    unique case (character)
                        CH_GT, CH_LT, CH_EQ, CH_BANG:
                        begin
                            mode_next   = MODE_OPERATOR;
                            tstart_next = pos_reg;
                            if (character == CH_GT)
                                pend_next = OP_GT;
                            else if (character == CH_LT)
                                pend_next = OP_LT;
                            else if (character == CH_EQ)
                                pend_next = OP_ASSIGN;
                            else
                                pend_next = OP_BANG;
                        end
                        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN:
                        begin
                            bundle.mask[1] = 1'b1;
                            if (character == CH_PLUS)
                                bundle.slot[1].kind = KIND_PLUS;
                            else if (character == CH_MINUS)
                                bundle.slot[1].kind = KIND_MINUS;
                            else if (character == CH_STAR)
                                bundle.slot[1].kind = KIND_MUL;
                            else if (character == CH_SLASH)
                                bundle.slot[1].kind = KIND_DIV;
                            else if (character == CH_LPAREN)
                                bundle.slot[1].kind = KIND_LPAREN;
                            else
                                bundle.slot[1].kind = KIND_RPAREN;
                            bundle.slot[1].err   = ERR_NONE;
                            bundle.slot[1].start = 32'(pos_reg);
                            bundle.slot[1].len   = 32'd1;
                            bundle.slot[1].line  = line_reg;
                        end
                        CH_NL:
                        begin
                            line_next      = line_inc;
                            bundle.mask[1] = 1'b1;
                            bundle.slot[1] = make_token(KIND_END, ERR_NONE, pos_reg,
                                                        32'd0, line_inc);
                        end
                        CH_SPACE, CH_CR, CH_NUL:
                        begin
                        end
                        CH_QUOTE, CH_APOS:
                        begin
                            mode_next   = MODE_STRING;
                            quote_next  = (character == CH_APOS);
                            tstart_next = pos_end;
                        end
                        default:
                        begin
                            bundle.mask[1] = 1'b1;
                            bundle.slot[1] = make_token(KIND_NUMBER, ERR_SYMBOL, pos_reg,
                                                        32'd1, line_reg);
                            halt_next = 1'b1;
                        end
                    endcase
                end
            end

            // end of text flushes the open token and closes the expression; an open string gives a quote error instead
            if (end_of_text && !halt_next)
            begin
                unique case (mode_next)
                    MODE_NUMBER:
                    begin
                        bundle.mask[1] = 1'b1;
                        bundle.slot[1] = make_token(KIND_NUMBER, ERR_NONE, tstart_next,
                                                    32'(diff_end), line_next);
                    end
                    MODE_IDENT:
                    begin
                        bundle.mask[1] = 1'b1;
                        bundle.slot[1] = make_token(KIND_IDENT, ERR_NONE, tstart_next,
                                                    32'(diff_end), line_next);
                    end
                    MODE_OPERATOR:
                    begin
                        bundle.mask[1] = 1'b1;
                        bundle.slot[1] = make_token(op_kind(pend_next, 1'b0), ERR_NONE,
                                                    tstart_next, 32'd1, line_next);
                    end
                    MODE_STRING:
                    begin
                        bundle.mask[1] = 1'b1;
                        bundle.slot[1] = make_token(KIND_NUMBER, ERR_QUOTE, tstart_next,
                                                    32'(diff_end), line_next);
                        halt_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (!halt_next)
                begin
                    bundle.mask[2] = 1'b1;
                    bundle.slot[2] = make_token(KIND_END, ERR_NONE, pos_end, 32'd0,
                                                line_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= OP_GT;
            quote_reg  <= 1'b0;
            tstart_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= 32'd1;
            halt_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (end_of_text)
            begin
                mode_reg   <= MODE_IDLE;
                pend_reg   <= OP_GT;
                quote_reg  <= 1'b0;
                tstart_reg <= '0;
                pos_reg    <= '0;
                line_reg   <= 32'd1;
                halt_reg   <= 1'b0;
            end
            else if (!halt_reg)
            begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                quote_reg  <= quote_next;
                tstart_reg <= tstart_next;
                pos_reg    <= pos_end;
                line_reg   <= line_next;
                halt_reg   <= halt_next;
            end
        end
    end

endmodule

/* rtl/core/exl_queue.sv */
// short queue of token bundles between scanner and output side
module exl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  exl_pkg::bundle_t wdata,
    output logic             full,
    input  logic             pop,
    output exl_pkg::bundle_t rdata,
    output logic             rvalid
);
    import exl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t            store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/exl_back.sv */
// output side: unpacks bundles into one token transfer per cycle while out_stall is low
module exl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  exl_pkg::bundle_t head,
    input  logic             head_valid,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [4:0]       token_kind,
    output logic [1:0]       error_code,
    output logic [31:0]      start_pos,
    output logic [31:0]      text_length,
    output logic [31:0]      line_number,
    output logic             last_of_run
);
    import exl_pkg::*;

    localparam int SEL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    bundle_t            work_reg;
    logic [SLOTS-1:0]   mask_reg, mask_next;
    logic               out_valid_reg;
    token_t             tok_reg;
    logic               last_reg;

    logic               load_out;
    logic               emit;
    logic [SEL_W-1:0]   sel;
    logic [SLOTS-1:0]   rem;
    logic [SLOTS-1:0]   mask_after;

    always_comb
    begin
        sel = '0;
        // lowest pending slot goes first
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = SEL_W'(i);
        end
        rem        = mask_reg & ~(SLOTS'(1) << sel);
        load_out   = !out_valid_reg || !out_stall;
        emit       = load_out && (|mask_reg);
        mask_after = emit ? rem : mask_reg;
        pop        = head_valid && (mask_after == '0);
        mask_next  = pop ? head.mask : mask_after;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            work_reg <= head;
        if (emit)
        begin
            tok_reg  <= work_reg.slot[sel];
            last_reg <= (rem == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (load_out)
                out_valid_reg <= |mask_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign token_kind  = tok_reg.kind;
    assign error_code  = tok_reg.err;
    assign start_pos   = tok_reg.start;
    assign text_length = tok_reg.len;
    assign line_number = tok_reg.line;
    assign last_of_run = last_reg;

endmodule

/* rtl/core/expression_lexer_core.sv */
// expression lexer top level: scanner, bundle queue and token output stage
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall   character, end_of_text
//  out      source     out_valid / out_stall token_kind, error_code, start_pos,
//                                            text_length, line_number, last_of_run
//
// the scanner takes one character per cycle while the two-entry bundle queue has room
// each character yields zero to three tokens; the output stage sends one token per
// cycle from its output register while out_stall is low
// rst_n clears scan state to the start of a text, line count one, queue empty
// an output stall backs up into the queue and then stalls the input; no token is lost
module expression_lexer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [1:0]  error_code,
    output logic [31:0] start_pos,
    output logic [31:0] text_length,
    output logic [31:0] line_number,
    output logic        last_of_run
);
    import exl_pkg::*;

    logic    push;
    logic    full;
    logic    pop;
    logic    head_valid;
    bundle_t push_data;
    bundle_t head;

    exl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .character   (character),
        .end_of_text (end_of_text),
        .queue_full  (full),
        .in_stall    (in_stall),
        .push        (push),
        .bundle      (push_data)
    );

    exl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (push_data),
        .full   (full),
        .pop    (pop),
        .rdata  (head),
        .rvalid (head_valid)
    );

    exl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .error_code  (error_code),
        .start_pos   (start_pos),
        .text_length (text_length),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

endmodule

/* rtl/core/exl_checker.sv */
// port-level checks for the expression lexer, bound to the top level
module exl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  character,
    input logic        end_of_text,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  token_kind,
    input logic [1:0]  error_code,
    input logic [31:0] start_pos,
    input logic [31:0] text_length,
    input logic [31:0] line_number,
    input logic        last_of_run
);
    import exl_pkg::*;

    // a stalled input transfer keeps its character
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(character) && $stable(end_of_text))
        else $error("input character changed while stalled");

    // a held transfer keeps its token
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind) &&
        $stable(start_pos) && $stable(text_length) && $stable(line_number) &&
        $stable(error_code) && $stable(last_of_run))
        else $error("output token changed while stalled");

    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |->
        token_kind == KIND_NUMBER && (error_code == ERR_SYMBOL || error_code == ERR_QUOTE))
        else $error("bad error result");

    a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_NONE && token_kind == KIND_END |-> text_length == '0)
        else $error("end_expr with nonzero length");

    // an error ends a run and carries a nonzero line number
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> last_of_run && line_number != '0)
        else $error("error result not final in run");

endmodule

bind expression_lexer_core exl_checker u_exl_checker (.*);
